[hdl/shl_pkg.sv]
// shared types, codes and sizes for the sorted handle list
package shl_pkg;

    // list size and derived widths
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // field widths
    localparam int OP_W     = 2;
    localparam int HANDLE_W = 8;
    localparam int KEY_W    = 8;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // entry count of a full list as it shows on the 5-bit count port
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    // one slot of the list
    typedef struct packed {
        logic                valid;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                ins_en;
        logic                rem_en;
        logic                clr_en;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
    } cmd_t;

endpackage

[hdl/shl_cell.sv]
// one slot of the sorted list with its insert and remove compare
module shl_cell
    import shl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cmd_t   cmd,
    input  entry_t left_entry,
    input  logic   left_keep,
    input  entry_t right_entry,
    input  logic   found_in,
    output entry_t entry,
    output logic   keep,
    output logic   found_out
);

    logic                valid_reg;
    logic                valid_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] handle_next;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    key_next;
    logic                match;

    // compares against the broadcast key and handle
    assign keep      = valid_reg && (key_reg <= cmd.key);
    assign match     = valid_reg && (key_reg == cmd.key) && (handle_reg == cmd.handle);
    assign found_out = found_in || match;

    assign entry.valid  = valid_reg;
    assign entry.handle = handle_reg;
    assign entry.key    = key_reg;

    // next slot contents
    always_comb
    begin
        valid_next  = valid_reg;
        handle_next = handle_reg;
        key_next    = key_reg;
        if (cmd.clr_en)
        begin
            valid_next  = 1'b0;
            handle_next = '0;
            key_next    = '0;
        end
        else if (cmd.ins_en && !keep)
        begin
            if (left_keep)
            begin
                valid_next  = 1'b1;
                handle_next = cmd.handle;
                key_next    = cmd.key;
            end
            else
            begin
                valid_next  = left_entry.valid;
                handle_next = left_entry.handle;
                key_next    = left_entry.key;
            end
        end
        else if (cmd.rem_en && found_out)
        begin
            valid_next  = right_entry.valid;
            handle_next = right_entry.handle;
            key_next    = right_entry.key;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        handle_reg <= handle_next;
        key_reg    <= key_next;
    end

endmodule

[hdl/sorted_handle_list.sv]
// Sorted handle list: a packed list of up to DEPTH (handle, key) entries kept
// in ascending key order, built as a row of slot cells that each compare the
// request against their own entry and take their neighbor's entry to shift.
// A request is taken at any clock edge where start is high; busy stays low,
// so a new request may follow in every cycle. Every request, insert, remove,
// read or clear, is handled alike: the cells update at the accepting edge and
// the result shows with done high in the following cycle, for that cycle
// only. The receiver cannot stall the result. An insert lands after all
// entries of equal key; an insert into a full list reports full, a remove of
// an absent entry reports not found, and entry_count gives the fill level
// after the request.
module sorted_handle_list
    import shl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     opcode,
    input  logic [HANDLE_W-1:0] handle,
    input  logic [KEY_W-1:0]    sort_key,
    input  logic [POS_W-1:0]    position,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [HANDLE_W-1:0] read_handle,
    output logic [KEY_W-1:0]    read_key,
    output logic                read_valid,
    output logic [COUNT_W-1:0]  entry_count
);

    logic                      accept;
    logic                      full;
    logic                      found_any;
    cmd_t                      cmd;
    entry_t                    ent   [DEPTH];
    logic                      keep  [DEPTH];
    logic                      found [DEPTH];
    logic [IDX_W+POS_W-1:0]    pos_ext;
    logic                      pos_in_range;
    entry_t                    rd_entry;
    logic                      done_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic [HANDLE_W-1:0]       rd_handle_reg;
    logic [HANDLE_W-1:0]       rd_handle_next;
    logic [KEY_W-1:0]          rd_key_reg;
    logic [KEY_W-1:0]          rd_key_next;
    logic                      rd_valid_reg;
    logic                      rd_valid_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic [CNT_W+COUNT_W-1:0]  cnt_wide;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // list state seen at the tail of the chain
    assign full      = ent[DEPTH-1].valid;
    assign found_any = found[DEPTH-1];

    // request broadcast to the cells
    assign cmd.ins_en = accept && (opcode == OP_INSERT) && !full;
    assign cmd.rem_en = accept && (opcode == OP_REMOVE);
    assign cmd.clr_en = accept && (opcode == OP_CLEAR);
    assign cmd.handle = handle;
    assign cmd.key    = sort_key;

    // row of slot cells
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_k;
            logic   f_in;

            if (gi == 0)
            begin : g_head
                assign left_e = '0;
                assign left_k = 1'b1;
                assign f_in   = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = ent[gi-1];
                assign left_k = keep[gi-1];
                assign f_in   = found[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_body
                assign right_e = ent[gi+1];
            end

            shl_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_entry  (left_e),
                .left_keep   (left_k),
                .right_entry (right_e),
                .found_in    (f_in),
                .entry       (ent[gi]),
                .keep        (keep[gi]),
                .found_out   (found[gi])
            );
        end
    endgenerate

    // read port select
    assign pos_ext      = {{IDX_W{1'b0}}, position};
    assign pos_in_range = (pos_ext < (IDX_W+POS_W)'(DEPTH));
    assign rd_entry     = ent[pos_ext[IDX_W-1:0]];

    // result and count for the request
    always_comb
    begin
        status_next    = ST_OK;
        rd_handle_next = '0;
        rd_key_next    = '0;
        rd_valid_next  = 1'b0;
        cnt_next       = cnt_reg;
        case (opcode)
            OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (found_any)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_READ:
            begin
                if (pos_in_range && rd_entry.valid)
                begin
                    rd_handle_next = rd_entry.handle;
                    rd_key_next    = rd_entry.key;
                    rd_valid_next  = 1'b1;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            rd_handle_reg <= rd_handle_next;
            rd_key_reg    <= rd_key_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    // count on the port is masked to its width
    assign cnt_wide = {{COUNT_W{1'b0}}, cnt_reg};

    assign done        = done_reg;
    assign status      = status_reg;
    assign read_handle = rd_handle_reg;
    assign read_key    = rd_key_reg;
    assign read_valid  = rd_valid_reg;
    assign entry_count = cnt_wide[COUNT_W-1:0];

endmodule

[hdl/shl_checker.sv]
// port-level checks for the sorted handle list and their bind
module shl_checker
    import shl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic [HANDLE_W-1:0] read_handle,
    input logic [KEY_W-1:0]    read_key,
    input logic                read_valid,
    input logic [COUNT_W-1:0]  entry_count
);

    // every accepted request gives its result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("request without result");

    // no result appears without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without request");

    // a full report comes only with a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> (entry_count == FULL_COUNT))
        else $error("full status with list not full");

    // a result with no entry read carries zero read fields
    a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !read_valid) |-> ((read_handle == '0) && (read_key == '0)))
        else $error("read fields set without an entry");

    // the count moves only together with a result
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(entry_count) |-> done)
        else $error("entry count changed without a request");

endmodule

bind sorted_handle_list shl_checker u_shl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .read_handle (read_handle),
    .read_key    (read_key),
    .read_valid  (read_valid),
    .entry_count (entry_count)
);

[sim/tb.sv]
// self-checking testbench for the sorted handle list
`timescale 1ns / 100ps

module tb;
    import shl_pkg::*;

    // one result of the list, as it shows on the ports
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] rd_handle;
        logic [KEY_W-1:0]    rd_key;
        logic                rd_valid;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    // one row of the directed table; fixed rows carry their result typed in
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] hnd;
        logic [KEY_W-1:0]    key;
        logic [POS_W-1:0]    pos;
        logic [4:0]          reps;
        logic                fixed;
        list_result_t        res;
    } list_row_t;

    localparam int NUM_ROWS   = 18;
    localparam int NUM_RANDOM = 900;
    localparam int BURST_LEN  = 50;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     opcode = OP_READ;
    logic [HANDLE_W-1:0] handle = '0;
    logic [KEY_W-1:0]    sort_key = '0;
    logic [POS_W-1:0]    position = '0;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] read_handle;
    logic [KEY_W-1:0]    read_key;
    logic                read_valid;
    logic [COUNT_W-1:0]  entry_count;

    // fixed expectation that travels with the request on the ports
    logic                fixed_row = 1'b0;
    list_result_t        fixed_result = '0;

    // predicted list contents
    logic [HANDLE_W-1:0] pred_handle [DEPTH];
    logic [KEY_W-1:0]    pred_key [DEPTH];
    logic                pred_valid [DEPTH];

    list_result_t        pending_results [$];
    list_result_t        oldest;
    list_result_t        predicted;
    int                  error_count = 0;

    // pairs inserted by the driver, used to aim removes at live entries
    logic [15:0]         inserted_pairs [$];
    list_row_t           plan [NUM_ROWS];

    sorted_handle_list uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .handle      (handle),
        .sort_key    (sort_key),
        .position    (position),
        .done        (done),
        .status      (status),
        .read_handle (read_handle),
        .read_key    (read_key),
        .read_valid  (read_valid),
        .entry_count (entry_count)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor: applies one request to the shadow list and returns its result
    function automatic list_result_t apply_request(
        input logic [OP_W-1:0]     op,
        input logic [HANDLE_W-1:0] h,
        input logic [KEY_W-1:0]    k,
        input logic [POS_W-1:0]    pos
    );
        list_result_t r;
        int           p;
        int           n;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INSERT:
            begin
                if (pred_valid[DEPTH-1])
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // new entry goes behind every entry of equal or smaller key
                    p = 0;
                    while (p < DEPTH && pred_valid[p] && pred_key[p] <= k)
                        p++;
                    for (int i = DEPTH - 1; i > p; i--)
                    begin
                        pred_handle[i] = pred_handle[i-1];
                        pred_key[i]    = pred_key[i-1];
                        pred_valid[i]  = pred_valid[i-1];
                    end
                    pred_handle[p] = h;
                    pred_key[p]    = k;
                    pred_valid[p]  = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                // first entry matching both key and handle
                p = DEPTH;
                for (int i = DEPTH - 1; i >= 0; i--)
                    if (pred_valid[i] && pred_key[i] == k && pred_handle[i] == h)
                        p = i;
                if (p == DEPTH)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    for (int i = p; i + 1 < DEPTH; i++)
                    begin
                        pred_handle[i] = pred_handle[i+1];
                        pred_key[i]    = pred_key[i+1];
                        pred_valid[i]  = pred_valid[i+1];
                    end
                    pred_handle[DEPTH-1] = '0;
                    pred_key[DEPTH-1]    = '0;
                    pred_valid[DEPTH-1]  = 1'b0;
                end
            end
            OP_READ:
            begin
                if (int'(pos) < DEPTH && pred_valid[pos])
                begin
                    r.rd_handle = pred_handle[pos];
                    r.rd_key    = pred_key[pos];
                    r.rd_valid  = 1'b1;
                end
            end
            default:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    pred_handle[i] = '0;
                    pred_key[i]    = '0;
                    pred_valid[i]  = 1'b0;
                end
            end
        endcase
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            n += pred_valid[i] ? 1 : 0;
        r.count = COUNT_W'(n);
        return r;
    endfunction

    // mismatch report: one line per bad field
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // empty shadow list at reset
    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            pred_handle[i] = '0;
            pred_key[i]    = '0;
            pred_valid[i]  = 1'b0;
        end
    end

    // result checking, then prediction for a request taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with no request waiting", 1, 0);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (status !== oldest.status)
                        report_mismatch("status", status, oldest.status);
                    if (read_handle !== oldest.rd_handle)
                        report_mismatch("read_handle", read_handle, oldest.rd_handle);
                    if (read_key !== oldest.rd_key)
                        report_mismatch("read_key", read_key, oldest.rd_key);
                    if (read_valid !== oldest.rd_valid)
                        report_mismatch("read_valid", read_valid, oldest.rd_valid);
                    if (entry_count !== oldest.count)
                        report_mismatch("entry_count", entry_count, oldest.count);
                end
            end
            if (start && !busy)
            begin
                predicted = apply_request(opcode, handle, sort_key, position);
                pending_results.push_back(fixed_row ? fixed_result : predicted);
            end
        end
    end

    // idle cycles before a request: mostly none or short, now and then long
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // drive one request and hold it until the block takes it
    task automatic send_request(
        input logic [OP_W-1:0]     op,
        input logic [HANDLE_W-1:0] h,
        input logic [KEY_W-1:0]    k,
        input logic [POS_W-1:0]    pos,
        input logic                fixed,
        input list_result_t        res,
        input bit                  quiet
    );
        int  gap;
        bit  taken;
        gap = pick_gap(quiet);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        handle       <= h;
        sort_key     <= k;
        position     <= pos;
        fixed_row    <= fixed;
        fixed_result <= res;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // directed table, then random traffic, then drain
    initial
    begin
        list_row_t           row;
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] h;
        logic [KEY_W-1:0]    k;
        logic [15:0]         pair;
        int                  r;
        int                  idx;
        bit                  filling;
        bit                  quiet;
        bit                  narrow;

        // empty list, misses, equal keys, key extremes, duplicates, full list
        plan[0]  = '{OP_READ,   8'h00, 8'h00, 4'd0,  5'd1,  1'b1,
                     '{ST_OK, 8'h00, 8'h00, 1'b0, 5'd0}};
        plan[1]  = '{OP_REMOVE, 8'h05, 8'h05, 4'd0,  5'd1,  1'b1,
                     '{ST_NOT_FOUND, 8'h00, 8'h00, 1'b0, 5'd0}};
        plan[2]  = '{OP_INSERT, 8'h00, 8'h80, 4'd0,  5'd1,  1'b0, '0};
        plan[3]  = '{OP_INSERT, 8'hFF, 8'h80, 4'd0,  5'd1,  1'b0, '0};
        plan[4]  = '{OP_INSERT, 8'h11, 8'h00, 4'd0,  5'd1,  1'b0, '0};
        plan[5]  = '{OP_INSERT, 8'h22, 8'hFF, 4'd0,  5'd1,  1'b0, '0};
        plan[6]  = '{OP_INSERT, 8'hFF, 8'h80, 4'd0,  5'd1,  1'b0, '0};
        plan[7]  = '{OP_READ,   8'h00, 8'h00, 4'd2,  5'd1,  1'b0, '0};
        plan[8]  = '{OP_READ,   8'h00, 8'h00, 4'd15, 5'd1,  1'b1,
                     '{ST_OK, 8'h00, 8'h00, 1'b0, 5'd5}};
        plan[9]  = '{OP_REMOVE, 8'hFF, 8'h80, 4'd0,  5'd1,  1'b0, '0};
        plan[10] = '{OP_REMOVE, 8'h80, 8'hFF, 4'd0,  5'd1,  1'b1,
                     '{ST_NOT_FOUND, 8'h00, 8'h00, 1'b0, 5'd4}};
        plan[11] = '{OP_CLEAR,  8'h00, 8'h00, 4'd0,  5'd1,  1'b1,
                     '{ST_OK, 8'h00, 8'h00, 1'b0, 5'd0}};
        plan[12] = '{OP_INSERT, 8'hA5, 8'h40, 4'd0,  5'(DEPTH), 1'b0, '0};
        plan[13] = '{OP_INSERT, 8'h5A, 8'hC3, 4'd0,  5'd1,  1'b1,
                     '{ST_FULL, 8'h00, 8'h00, 1'b0, FULL_COUNT}};
        plan[14] = '{OP_READ,   8'h00, 8'h00, 4'd15, 5'd1,  1'b0, '0};
        plan[15] = '{OP_REMOVE, 8'hA5, 8'h40, 4'd0,  5'd1,  1'b0, '0};
        plan[16] = '{OP_INSERT, 8'h5A, 8'hC3, 4'd0,  5'd1,  1'b0, '0};
        plan[17] = '{OP_CLEAR,  8'hFF, 8'hFF, 4'd15, 5'd1,  1'b1,
                     '{ST_OK, 8'h00, 8'h00, 1'b0, 5'd0}};

        // reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = plan[i];
            for (int j = 0; j < row.reps; j++)
                send_request(row.op, row.hnd, row.key, row.pos, row.fixed, row.res,
                             1'b0);
        end

        // random traffic in bursts that lean toward filling or draining the list
        filling = 1'b1;
        quiet   = 1'b0;
        narrow  = 1'b0;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % BURST_LEN == 0)
            begin
                filling = $urandom_range(0, 99) < 60;
                quiet   = $urandom_range(0, 99) < 25;
                narrow  = $urandom_range(0, 99) < 40;
            end
            r = $urandom_range(0, 99);
            if (r < (filling ? 65 : 25))
                op = OP_INSERT;
            else if (r < (filling ? 80 : 70))
                op = OP_REMOVE;
            else if (r < 98)
                op = OP_READ;
            else
                op = OP_CLEAR;
            h = narrow ? HANDLE_W'($urandom_range(0, 3)) : HANDLE_W'($urandom_range(0, 255));
            k = narrow ? KEY_W'($urandom_range(0, 3)) : KEY_W'($urandom_range(0, 255));

            // aim most removes at an entry that was inserted
            if (op == OP_REMOVE && inserted_pairs.size() != 0 && $urandom_range(0, 99) < 80)
            begin
                idx  = $urandom_range(0, inserted_pairs.size() - 1);
                pair = inserted_pairs[idx];
                inserted_pairs.delete(idx);
                k = pair[15:8];
                h = pair[7:0];
            end
            else if (op == OP_INSERT)
            begin
                inserted_pairs.push_back({k, h});
                if (inserted_pairs.size() > 4 * DEPTH)
                    void'(inserted_pairs.pop_front());
            end
            else if (op == OP_CLEAR)
            begin
                inserted_pairs.delete();
            end

            send_request(op, h, k, POS_W'($urandom_range(0, 15)), 1'b0, '0, quiet);
        end

        // drain
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
hdl/shl_pkg.sv
hdl/shl_cell.sv
hdl/sorted_handle_list.sv
hdl/shl_checker.sv
sim/tb.sv
